// ===== rtl/mrse_pkg.sv =====
// Package: SHA-256 constants and shared types for the Merkle root engine
`timescale 1ns / 1ps
package mrse_pkg;

  localparam int MaxLevelsDefault = 32;

  localparam logic [255:0] ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] TagLeaf  = 8'h00;
  localparam logic [7:0] TagInner = 8'h01;
  localparam logic [7:0] TagEmpty = 8'h02;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  typedef struct packed {
    logic mode;
    logic [63:0] data_word;
    logic [3:0] byte_count;
    logic leaf_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] root_word;
    logic [1:0] word_index;
    logic last;
    logic overflow;
  } out_item_t;

endpackage

// ===== rtl/mrse_if.sv =====
// Interfaces: valid/ready channels for leaf chunks and root words
`timescale 1ns / 1ps
interface mrse_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [63:0] data_word;
  logic [3:0] byte_count;
  logic leaf_end;
  modport source (output valid, mode, data_word, byte_count, leaf_end, input ready);
  modport sink (input valid, mode, data_word, byte_count, leaf_end, output ready);
endinterface

interface mrse_out_if;
  logic valid;
  logic ready;
  logic [63:0] root_word;
  logic [1:0] word_index;
  logic last;
  logic overflow;
  modport source (output valid, root_word, word_index, last, overflow, input ready);
  modport sink (input valid, root_word, word_index, last, overflow, output ready);
endinterface

// ===== rtl/mrse_compress.sv =====
// SHA-256 compression: one round per cycle over a 16-word message window
`timescale 1ns / 1ps
module mrse_compress (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] cv_in,
  input  logic [511:0] block,
  output logic         done,
  output logic [255:0] cv_out
);

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  rnd;
  logic        busy;
  logic [31:0] t1, t2, s0, s1, wnew;

  always_comb begin
    t1 = h + (mrse_pkg::rotr(e, 6) ^ mrse_pkg::rotr(e, 11) ^ mrse_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + mrse_pkg::sha_k(rnd) + w[0];
    t2 = (mrse_pkg::rotr(a, 2) ^ mrse_pkg::rotr(a, 13) ^ mrse_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    s0 = mrse_pkg::rotr(w[1], 7) ^ mrse_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = mrse_pkg::rotr(w[14], 17) ^ mrse_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
  end

  // done pulses after round 63; cv_out holds the new chain value from the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
      done <= 1'b0;
      {a, b, c, d, e, f, g, h} <= cv_in;
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      cv_out <= cv_in;
    end else if (busy) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      rnd  <= rnd + 6'd1;
      busy <= (rnd != 6'd63);
      done <= (rnd == 6'd63);
    end else begin
      done <= 1'b0;
      if (done) begin
        cv_out <= {cv_out[255:224] + a, cv_out[223:192] + b, cv_out[191:160] + c,
                   cv_out[159:128] + d, cv_out[127:96] + e, cv_out[95:64] + f,
                   cv_out[63:32] + g, cv_out[31:0] + h};
      end
    end
  end

endmodule

// ===== rtl/merkle_root_sha256_engine_core.sv =====
// Top level: Merkle root engine over SHA-256 with leaf/inner/empty tags
`timescale 1ns / 1ps
// Usage
//   in  : leaf chunks (mode 0) of up to eight bytes, first byte in bits 63..56;
//         leaf_end closes a leaf. A beat with mode 1 finishes the leaf set.
//   out : four beats per finish, root digest words 0..3, last on word 3,
//         overflow set when more than 2^MAX_LEVELS leaves were offered.
// Timing
//   One byte enters the message block per cycle while no block is hashed;
//   each full 64-byte block goes through start, the shared round unit and
//   the chain update. A chunk frees the input once its bytes (and the tag
//   byte of a leaf's first chunk) are in and each block it fills is hashed.
//   Closing a leaf pads one byte per cycle up to byte 56, writes the length
//   and hashes the last block. A merged level hashes tag and both digests.
//   A finish scans one level per cycle over MAX_LEVELS+1 levels, pausing
//   at occupied ones, hashes the empty tag if none, then the four beats.
// Reset
//   rst (synchronous) empties the tree: no open leaf, no occupied level,
//   leaf count and overflow cleared. The same happens after each root.
// Stall
//   in.ready is low from acceptance until the item is fully absorbed; while
//   a root word waits on out.ready the block holds it and takes no input.
module merkle_root_sha256_engine_core #(
  parameter int MAX_LEVELS = mrse_pkg::MaxLevelsDefault
) (
  input logic clk,
  input logic rst,
  mrse_in_if.sink   in,
  mrse_out_if.source out
);

  localparam int Slots = MAX_LEVELS + 1;
  localparam int LvlW  = $clog2(Slots + 1);
  localparam int AddrW = $clog2(Slots);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_BYTES  = 11'b00000000010,
    S_KICK   = 11'b00000000100,
    S_COMP   = 11'b00000001000,
    S_CVUP   = 11'b00000010000,
    S_PAD    = 11'b00000100000,
    S_MERGE  = 11'b00001000000,
    S_MRD    = 11'b00010000000,
    S_FOLD   = 11'b00100000000,
    S_FRD    = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  // what to do once a hash has finished
  typedef enum logic [3:0] {
    R_LEAF  = 4'b0001,
    R_MERGE = 4'b0010,
    R_FOLD  = 4'b0100,
    R_EMPTY = 4'b1000
  } ret_t;

  state_t       state;
  state_t       resume;
  ret_t         ret;
  logic [255:0] cv;
  logic [511:0] blk;
  logic [63:0]  mlen;
  logic [63:0]  bitlen;
  logic [255:0] stack_mem [Slots];
  logic [255:0] rd_data;
  logic [Slots-1:0] lvl_valid;
  logic         leaf_open;
  logic         ovf;
  logic         finishing;
  logic         have;
  logic [255:0] carry;
  logic [255:0] root;
  logic [63:0]  chunk;
  logic [3:0]   left;
  logic [LvlW-1:0]  lvl;
  logic [AddrW-1:0] slot;
  logic         merge_hit;
  logic         mem_we;
  // byte feeder: tag and digests of a message queued as a shift line
  logic [527:0] feed;
  logic [6:0]   feed_n;
  logic         pad_phase;   // message complete once queued bytes are in
  logic         pad_mark;    // 0x80 already written
  logic         final_blk;   // compression in flight is the last block
  logic [1:0]   widx;
  logic [31:0]  leaf_count;
  logic         cstart, cdone;
  logic [255:0] cv_out;
  logic [7:0]   cur_byte;
  logic [5:0]   pos;

  mrse_compress u_comp (
    .clk(clk), .rst(rst), .start(cstart), .cv_in(cv), .block(blk),
    .done(cdone), .cv_out(cv_out)
  );

  assign pos = mlen[5:0];
  assign cstart = (state == S_KICK);
  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_EMIT);
  assign out.root_word = root[255 - 64*widx -: 64];
  assign out.word_index = widx;
  assign out.last = (widx == 2'd3);
  assign out.overflow = ovf;

  assign slot = (lvl < LvlW'(Slots)) ? lvl[AddrW-1:0] : '0;
  assign merge_hit = (lvl < LvlW'(MAX_LEVELS)) && lvl_valid[slot];
  assign mem_we = (state == S_MERGE) && !merge_hit;

  // tag / digest bytes go before the chunk bytes
  always_comb begin
    cur_byte = (feed_n != 7'd0) ? feed[527:520] : chunk[63:56];
  end

  // per-level stack: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[slot] <= carry;
    rd_data <= stack_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; lvl_valid <= '0; leaf_open <= 1'b0; ovf <= 1'b0;
      leaf_count <= '0; mlen <= '0; cv <= mrse_pkg::ShaIv; widx <= '0;
      left <= '0; feed_n <= '0; finishing <= 1'b0; have <= 1'b0; lvl <= '0;
      pad_phase <= 1'b0; pad_mark <= 1'b0; final_blk <= 1'b0;
      resume <= S_BYTES; ret <= R_LEAF;
    end else begin
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            if (in.mode) begin
              finishing <= 1'b1;
              lvl <= '0;
              have <= 1'b0;
              if (leaf_open) begin
                // close the open leaf first
                ret <= R_LEAF;
                bitlen <= {mlen[60:0], 3'b000};
                pad_mark <= 1'b0;
                state <= S_PAD;
              end else begin
                state <= S_FOLD;
              end
            end else begin
              finishing <= 1'b0;
              chunk <= in.data_word;
              left <= (in.byte_count > 4'd8) ? 4'd8 : in.byte_count;
              pad_phase <= in.leaf_end;
              ret <= R_LEAF;
              if (!leaf_open) begin
                cv <= mrse_pkg::ShaIv; mlen <= '0;
                feed <= {mrse_pkg::TagLeaf, 520'b0}; feed_n <= 7'd1;
                leaf_open <= 1'b1;
              end
              state <= S_BYTES;
            end
          end
        end
        S_BYTES: begin
          if (feed_n != 7'd0 || left != 4'd0) begin
            blk[511 - 8*pos -: 8] <= cur_byte;
            mlen <= mlen + 64'd1;
            if (feed_n != 7'd0) begin
              feed <= feed << 8; feed_n <= feed_n - 7'd1;
            end else begin
              chunk <= chunk << 8; left <= left - 4'd1;
            end
            if (pos == 6'd63) begin
              resume <= S_BYTES; state <= S_KICK;
            end
          end else if (pad_phase) begin
            bitlen <= {mlen[60:0], 3'b000};
            pad_mark <= 1'b0;
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_KICK: state <= S_COMP;
        S_COMP: begin
          if (cdone) state <= S_CVUP;
        end
        S_CVUP: begin
          // chain value from the round unit is ready here, the cycle after done
          cv <= cv_out;
          if (!final_blk) begin
            state <= resume;
          end else begin
            final_blk <= 1'b0;
            case (ret)
              R_LEAF: begin
                carry <= cv_out;
                leaf_open <= 1'b0;
                lvl <= '0;
                if (lvl_valid[MAX_LEVELS]) begin
                  // tree full: leaf dropped
                  ovf <= 1'b1;
                  have <= 1'b0;
                  finishing <= 1'b0;
                  state <= finishing ? S_FOLD : S_IDLE;
                end else begin
                  state <= S_MERGE;
                end
              end
              R_MERGE: begin
                carry <= cv_out; lvl <= lvl + 1'b1; state <= S_MERGE;
              end
              R_FOLD: begin
                root <= cv_out; lvl <= lvl + 1'b1; state <= S_FOLD;
              end
              R_EMPTY: begin
                root <= cv_out; widx <= '0; state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PAD: begin
          // 0x80, zeros up to byte 56, then the 64-bit bit length
          if (!pad_mark || pos != 6'd56) begin
            blk[511 - 8*pos -: 8] <= pad_mark ? 8'h00 : 8'h80;
            mlen <= mlen + 64'd1;
            pad_mark <= 1'b1;
            if (pos == 6'd63) begin
              resume <= S_PAD; state <= S_KICK;
            end
          end else begin
            blk[63:0] <= bitlen;
            final_blk <= 1'b1;
            state <= S_KICK;
          end
        end
        S_MERGE: begin
          if (merge_hit) begin
            state <= S_MRD;
          end else begin
            // carry lands here; stack write happens alongside
            lvl_valid[slot] <= 1'b1;
            if (leaf_count != '1) leaf_count <= leaf_count + 32'd1;
            lvl <= '0;
            have <= 1'b0;
            finishing <= 1'b0;
            state <= finishing ? S_FOLD : S_IDLE;
          end
        end
        S_MRD: begin
          cv <= mrse_pkg::ShaIv; mlen <= '0;
          feed <= {mrse_pkg::TagInner, rd_data, carry, 8'h00}; feed_n <= 7'd65;
          pad_phase <= 1'b1;
          ret <= R_MERGE;
          lvl_valid[slot] <= 1'b0;
          state <= S_BYTES;
        end
        S_FOLD: begin
          if (lvl == LvlW'(Slots)) begin
            if (have) begin
              widx <= '0; state <= S_EMIT;
            end else begin
              cv <= mrse_pkg::ShaIv; mlen <= '0;
              feed <= {mrse_pkg::TagEmpty, 520'b0}; feed_n <= 7'd1;
              pad_phase <= 1'b1;
              ret <= R_EMPTY;
              state <= S_BYTES;
            end
          end else if (lvl_valid[slot]) begin
            state <= S_FRD;
          end else begin
            lvl <= lvl + 1'b1;
          end
        end
        S_FRD: begin
          if (!have) begin
            root <= rd_data; have <= 1'b1; lvl <= lvl + 1'b1; state <= S_FOLD;
          end else begin
            cv <= mrse_pkg::ShaIv; mlen <= '0;
            feed <= {mrse_pkg::TagInner, rd_data, root, 8'h00}; feed_n <= 7'd65;
            pad_phase <= 1'b1;
            ret <= R_FOLD;
            state <= S_BYTES;
          end
        end
        S_EMIT: begin
          if (out.ready) begin
            if (widx == 2'd3) begin
              // root out: back to an empty tree
              lvl_valid <= '0; leaf_open <= 1'b0; ovf <= 1'b0; leaf_count <= '0;
              mlen <= '0; cv <= mrse_pkg::ShaIv; widx <= '0;
              state <= S_IDLE;
            end else begin
              widx <= widx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !out.valid) else $error("ready while emitting");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.last |-> widx == 2'd3) else $error("last misplaced");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid) else $error("word dropped");
  a_emit_stable: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> $stable(out.root_word) && $stable(out.word_index))
    else $error("word changed while stalled");
`endif

endmodule

// ===== test/tb_merkle_root_sha256_engine_core.sv =====
// Testbench: Merkle root engine checked beat by beat against a SHA-256 tree predictor
`timescale 1ns / 1ps
module tb_merkle_root_sha256_engine_core;

  localparam int Levels    = mrse_pkg::MaxLevelsDefault;
  localparam int CycleCap  = 1000000;
  localparam int HoldOff   = 600;   // long receiver stall, cycles
  localparam int DrainWait = 400;   // idle cycles after last root beat

  // SHA-256 round constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk;
  logic rst;

  mrse_in_if  chunk_if ();
  mrse_out_if root_if ();

  merkle_root_sha256_engine_core u_top (
    .clk (clk),
    .rst (rst),
    .in  (chunk_if.sink),
    .out (root_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: whole-message SHA-256 plus the per-level pending stack.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha256_of(input logic [7:0] msg[$]);
    logic [7:0]  buf_q[$];
    logic [63:0] nbits;
    logic [31:0] h[8];
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    logic [255:0] dig;
    buf_q = msg;
    nbits = 64'(msg.size()) << 3;
    buf_q = {buf_q, 8'h80};
    while ((buf_q.size() % 64) != 56) buf_q = {buf_q, 8'h00};
    for (int i = 7; i >= 0; i--) buf_q = {buf_q, nbits[8*i +: 8]};
    for (int i = 0; i < 8; i++) h[i] = mrse_pkg::ShaIv[255 - 32*i -: 32];
    for (int blk = 0; blk < buf_q.size() / 64; blk++) begin
      for (int i = 0; i < 16; i++)
        w[i] = {buf_q[blk*64 + 4*i], buf_q[blk*64 + 4*i + 1],
                buf_q[blk*64 + 4*i + 2], buf_q[blk*64 + 4*i + 3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int i = 0; i < 64; i++) begin
        t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
             + RoundK[i] + w[i];
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    end
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = h[i];
    return dig;
  endfunction

  function automatic logic [255:0] node_hash(input logic [255:0] left, input logic [255:0] right);
    logic [7:0] m[$];
    m = {m, mrse_pkg::TagInner};
    for (int i = 31; i >= 0; i--) m = {m, left[8*i +: 8]};
    for (int i = 31; i >= 0; i--) m = {m, right[8*i +: 8]};
    return sha256_of(m);
  endfunction

  logic [7:0]    leaf_bytes[$];
  logic          leaf_busy;
  logic [255:0]  level_hash[Levels + 1];
  logic [Levels:0] level_full;
  logic          tree_ovf;
  mrse_pkg::out_item_t root_beats_q[$];

  task automatic tree_clear();
    leaf_bytes.delete();
    leaf_busy  = 1'b0;
    level_full = '0;
    tree_ovf   = 1'b0;
  endtask

  // Hash the open leaf and carry it up the stack like a binary counter
  task automatic close_leaf();
    logic [255:0] carry;
    int lvl;
    leaf_bytes.push_front(mrse_pkg::TagLeaf);
    carry = sha256_of(leaf_bytes);
    leaf_bytes.delete();
    leaf_busy = 1'b0;
    if (level_full[Levels]) begin
      tree_ovf = 1'b1;   // beyond capacity: leaf dropped
    end else begin
      lvl = 0;
      while (lvl < Levels && level_full[lvl]) begin
        carry = node_hash(level_hash[lvl], carry);
        level_full[lvl] = 1'b0;
        lvl++;
      end
      level_hash[lvl] = carry;
      level_full[lvl] = 1'b1;
    end
  endtask

  task automatic predict_beat(input mrse_pkg::in_item_t it);
    logic [255:0] root;
    logic have;
    logic [7:0] tag_q[$];
    mrse_pkg::out_item_t o;
    int n;
    if (it.mode == 1'b0) begin
      n = (it.byte_count > 8) ? 8 : int'(it.byte_count);
      leaf_busy = 1'b1;   // an empty chunk still opens a leaf
      for (int i = 0; i < n; i++) leaf_bytes = {leaf_bytes, it.data_word[63 - 8*i -: 8]};
      if (it.leaf_end) close_leaf();
    end else begin
      // finish: close any open leaf, then fold lowest level first
      if (leaf_busy) close_leaf();
      have = 1'b0;
      for (int lvl = 0; lvl <= Levels; lvl++) begin
        if (level_full[lvl]) begin
          root = have ? node_hash(level_hash[lvl], root) : level_hash[lvl];
          have = 1'b1;
        end
      end
      if (!have) begin
        tag_q = {tag_q, mrse_pkg::TagEmpty};
        root = sha256_of(tag_q);
      end
      for (int k = 0; k < 4; k++) begin
        o.root_word  = root[255 - 64*k -: 64];
        o.word_index = 2'(k);
        o.last       = (k == 3);
        o.overflow   = tree_ovf;
        root_beats_q = {root_beats_q, o};
      end
      tree_clear();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus queue and helpers
  // ---------------------------------------------------------------------------
  mrse_pkg::in_item_t chunk_q[$];
  int n_leaves, n_sets, n_beats_in, n_beats_out, n_fail, cycles;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_chunk(input logic [63:0] d, input logic [3:0] cnt, input logic lend);
    mrse_pkg::in_item_t it;
    it.mode = 1'b0; it.data_word = d; it.byte_count = cnt; it.leaf_end = lend;
    chunk_q = {chunk_q, it};
  endtask

  task automatic add_finish(input logic junk);
    mrse_pkg::in_item_t it;
    it.mode = 1'b1;
    it.data_word  = junk ? {$urandom, $urandom} : '0;
    it.byte_count = junk ? 4'($urandom) : '0;
    it.leaf_end   = junk ? 1'($urandom) : 1'b0;
    chunk_q = {chunk_q, it};
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents beats at the falling edge, with random gaps
  // ---------------------------------------------------------------------------
  logic in_took;
  logic drv_busy;
  int   drv_gap;
  mrse_pkg::in_item_t drv_cur;

  always @(negedge clk) begin
    if (rst) begin
      drv_busy = 1'b0;
      drv_gap  = 0;
    end else begin
      if (in_took) drv_busy = 1'b0;
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (chunk_q.size() > 0) begin
          drv_cur  = chunk_q.pop_front();
          drv_busy = 1'b1;
          drv_gap  = pick_gap();
        end
      end
    end
    chunk_if.valid      <= drv_busy;
    chunk_if.mode       <= drv_cur.mode;
    chunk_if.data_word  <= drv_cur.data_word;
    chunk_if.byte_count <= drv_cur.byte_count;
    chunk_if.leaf_end   <= drv_cur.leaf_end;
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  int  hold_cnt;
  int  rdy_gap;
  logic hold_done;

  always @(negedge clk) begin
    if (rst) begin
      hold_cnt  = 0;
      rdy_gap   = 0;
      hold_done = 1'b0;
      root_if.ready <= 1'b0;
    end else begin
      // stall for a long stretch once the second root starts, while the driver keeps offering chunks
      if (!hold_done && n_beats_out >= 4 && root_if.valid) begin
        hold_cnt  = HoldOff;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        root_if.ready <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap--;
        root_if.ready <= 1'b0;
      end else begin
        rdy_gap = pick_gap();
        root_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input beats, checks root beats, all at the rising edge
  // ---------------------------------------------------------------------------
  mrse_pkg::in_item_t seen;
  mrse_pkg::out_item_t want;

  always @(posedge clk) begin
    in_took = !rst && chunk_if.valid && chunk_if.ready;
    if (rst) begin
      cycles = 0;
    end else begin
      cycles++;
      if (cycles > CycleCap) begin
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
      end
      if (in_took) begin
        seen.mode = chunk_if.mode;
        seen.data_word = chunk_if.data_word;
        seen.byte_count = chunk_if.byte_count;
        seen.leaf_end = chunk_if.leaf_end;
        predict_beat(seen);
        n_beats_in++;
      end
      if (root_if.valid && root_if.ready) begin
        n_beats_out++;
        if (root_beats_q.size() == 0) begin
          $error("root beat with none expected: word %h", root_if.root_word);
          n_fail++;
        end else begin
          want = root_beats_q.pop_front();
          if (root_if.root_word !== want.root_word) begin
            $error("root_word expected %h actual %h", want.root_word, root_if.root_word);
            n_fail++;
          end
          if (root_if.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, root_if.word_index);
            n_fail++;
          end
          if (root_if.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, root_if.last);
            n_fail++;
          end
          if (root_if.overflow !== want.overflow) begin
            $error("overflow expected %0b actual %0b", want.overflow, root_if.overflow);
            n_fail++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed cases, random leaf sets, then drain
  // ---------------------------------------------------------------------------
  initial begin
    int nl, nc;
    n_fail = 0; n_beats_in = 0; n_beats_out = 0; n_leaves = 0; n_sets = 0;
    in_took = 1'b0;
    drv_cur = '0;
    tree_clear();
    chunk_if.valid = 1'b0; chunk_if.mode = 1'b0; chunk_if.data_word = '0;
    chunk_if.byte_count = '0; chunk_if.leaf_end = 1'b0;
    root_if.ready = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty leaf set
    add_finish(1'b0);
    // single empty leaf (zero-byte chunk), finish fields carrying junk
    add_chunk(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
    add_finish(1'b1);
    // all-ones bytes, count above eight, junk in unused low bytes
    add_chunk(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0);
    add_chunk(64'h0123_4567_89ab_cdef, 4'd15, 1'b0);
    add_chunk(64'h8000_0000_0000_00ff, 4'd1, 1'b1);
    // three leaves: odd last node promoted
    add_chunk(64'h0, 4'd8, 1'b1);
    add_chunk(64'haa55_aa55_aa55_aa55, 4'd3, 1'b1);
    add_finish(1'b0);
    // leaf still open at finish; 55 bytes so tag+data sits on a padding boundary
    for (int i = 0; i < 6; i++) add_chunk({$urandom, $urandom}, 4'd8, 1'b0);
    add_chunk({$urandom, $urandom}, 4'd7, 1'b0);
    add_finish(1'b1);
    // two leaves, 63 and 64 bytes with tag: full-block edges
    for (int i = 0; i < 7; i++) add_chunk({$urandom, $urandom}, 4'd8, 1'b0);
    add_chunk({$urandom, $urandom}, 4'd6, 1'b1);
    for (int i = 0; i < 7; i++) add_chunk({$urandom, $urandom}, 4'd9, 1'b0);
    add_chunk({$urandom, $urandom}, 4'd7, 1'b1);
    add_finish(1'b0);

    // random leaf sets, mostly small, now and then larger
    while (chunk_q.size() + n_beats_in < 260) begin
      nl = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      for (int l = 0; l < nl; l++) begin
        nc = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        for (int c = 0; c < nc; c++)
          add_chunk({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                    (c == nc - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0));
        n_leaves++;
      end
      add_finish($urandom_range(0, 1));
      n_sets++;
    end

    while (chunk_q.size() > 0 || drv_busy) @(posedge clk);
    while (root_beats_q.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("ran %0d input beats (%0d random leaf sets, about %0d leaves), %0d root beats",
             n_beats_in, n_sets, n_leaves, n_beats_out);
    $display("covered empty sets, zero-byte and oversize chunks, open-leaf finish, long stall");
    if (n_fail == 0 && root_beats_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mrse_pkg.sv
rtl/mrse_if.sv
rtl/mrse_compress.sv
rtl/merkle_root_sha256_engine_core.sv
test/tb_merkle_root_sha256_engine_core.sv
